// ----- rtl/dlst_pkg.sv -----
// ----------------------------------------------------------------------------
// dlst_pkg
// Shared types and constants for the delta-list sleep timer queue.
// ----------------------------------------------------------------------------
package dlst_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MAX_WAKE  = 16;
  localparam int ID_W      = 8;
  localparam int DLT_W     = 16;
  localparam int CMD_W     = 2;
  localparam int STS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_ADDED    = 3'd0,
    STS_IGNORED  = 3'd1,
    STS_FULL     = 3'd2,
    STS_REMOVED  = 3'd3,
    STS_NOTFOUND = 3'd4,
    STS_NONE     = 3'd5,
    STS_WOKEN    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REM,
    ST_DEC,
    ST_WAKE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SET_DELTA,
    CELL_FROM_PREV,
    CELL_FROM_PREV_SUB,
    CELL_FROM_NEXT,
    CELL_FROM_NEXT_ADD
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DLT_W-1:0] delta;
  } entry_t;

endpackage

// ----- rtl/dlst_cell.sv -----
// ----------------------------------------------------------------------------
// dlst_cell
// One queue slot: holds an id and its relative delay, loads from either
// neighbor or from the broadcast entry.
// ----------------------------------------------------------------------------
module dlst_cell
  import dlst_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  entry_t   prev_ent,
  input  entry_t   next_ent,
  input  entry_t   ld_ent,
  output entry_t   ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (op)
      CELL_HOLD:          ent_nxt = ent_r;
      CELL_LOAD:          ent_nxt = ld_ent;
      CELL_SET_DELTA:     ent_nxt.delta = ld_ent.delta;
      CELL_FROM_PREV:     ent_nxt = prev_ent;
      CELL_FROM_PREV_SUB: begin
        ent_nxt.id    = prev_ent.id;
        ent_nxt.delta = prev_ent.delta - ld_ent.delta;
      end
      CELL_FROM_NEXT:     ent_nxt = next_ent;
      CELL_FROM_NEXT_ADD: begin
        ent_nxt.id    = next_ent.id;
        ent_nxt.delta = next_ent.delta + ent_r.delta;
      end
      default:            ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ----- rtl/delta_list_sleep_timer_queue_unit.sv -----
// Add and remove walk the cell chain one cell per cycle; the result is
// registered once the walk reaches its deciding step. A tick first
// decrements the head delta (saturating at zero), then pops each woken id
// with one result each, up to MAX_WAKE ids, or one none result if none wake.
// Ignored adds, full queue, empty tick and bad commands answer from idle.
// Reset clears the fill count and control; cell contents are undefined.
// ----------------------------------------------------------------------------
// delta_list_sleep_timer_queue_unit
// Sorted delta-list sleep queue built as a row of shifting cells with a
// sequencing controller.
// ----------------------------------------------------------------------------
module delta_list_sleep_timer_queue_unit
  import dlst_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_proc_id,
  input  logic [DLT_W-1:0] in_sleep_time,
  output logic             out_valid,
  output logic [STS_W-1:0] out_status,
  output logic [ID_W-1:0]  out_woken_id,
  output logic             out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int WW = $clog2(MAX_WAKE + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     p_r, p_nxt;
  logic [DLT_W-1:0]  t_r, t_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [WW-1:0]     woke_r, woke_nxt;
  logic              ov_r, ov_nxt;
  status_t           os_r, os_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic              ol_r, ol_nxt;

  cell_op_t cell_op [DEPTH];
  entry_t   cell_ent [DEPTH];
  entry_t   ld_ent;
  entry_t   pe;
  logic [CW-1:0] p_inc;
  logic          wake_more;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      entry_t prev_e, next_e;
      if (g == 0) begin : g_first
        assign prev_e = '0;
      end else begin : g_mid
        assign prev_e = cell_ent[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_body
        assign next_e = cell_ent[g+1];
      end
      dlst_cell u_cell (
        .clk      (clk),
        .op       (cell_op[g]),
        .prev_ent (prev_e),
        .next_ent (next_e),
        .ld_ent   (ld_ent),
        .ent      (cell_ent[g])
      );
    end
  endgenerate

  assign pe    = cell_ent[p_r[AW-1:0]];
  assign p_inc = p_r + 1'b1;
  assign wake_more = (count_r > CW'(1)) && (woke_r < WW'(MAX_WAKE - 1)) &&
                     (cell_ent[1].delta == '0);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    p_nxt     = p_r;
    t_nxt     = t_r;
    id_nxt    = id_r;
    woke_nxt  = woke_r;
    ov_nxt    = 1'b0;
    os_nxt    = STS_ADDED;
    oid_nxt   = '0;
    ol_nxt    = 1'b0;
    ld_ent.id    = id_r;
    ld_ent.delta = t_r;
    for (int k = 0; k < DEPTH; k++) begin
      cell_op[k] = CELL_HOLD;
    end
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          id_nxt   = in_proc_id;
          t_nxt    = in_sleep_time;
          p_nxt    = '0;
          woke_nxt = '0;
          case (in_cmd)
            CMD_ADD: begin
              if (in_sleep_time == '0) begin
                ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_IGNORED;
              end else if (count_r == CW'(DEPTH)) begin
                ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_FULL;
              end else begin
                state_nxt = ST_ADD;
              end
            end
            CMD_REMOVE: state_nxt = ST_REM;
            CMD_TICK: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_NONE;
              end else begin
                state_nxt = ST_DEC;
              end
            end
            default: begin
              ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_IGNORED;
            end
          endcase
        end
      end
      ST_ADD: begin
        if ((p_r < count_r) && (pe.delta <= t_r)) begin
          t_nxt = t_r - pe.delta;
          p_nxt = p_inc;
        end else begin
          for (int k = 0; k < DEPTH; k++) begin
            if (CW'(k) == p_r) cell_op[k] = CELL_LOAD;
            else if (CW'(k) == p_inc) cell_op[k] = CELL_FROM_PREV_SUB;
            else if (CW'(k) > p_r) cell_op[k] = CELL_FROM_PREV;
          end
          count_nxt = count_r + 1'b1;
          ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_ADDED;
          state_nxt = ST_IDLE;
        end
      end
      ST_REM: begin
        if (p_r >= count_r) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_NOTFOUND;
          state_nxt = ST_IDLE;
        end else if (pe.id == id_r) begin
          for (int k = 0; k < DEPTH; k++) begin
            if (CW'(k) == p_r) cell_op[k] = CELL_FROM_NEXT_ADD;
            else if (CW'(k) > p_r) cell_op[k] = CELL_FROM_NEXT;
          end
          count_nxt = count_r - 1'b1;
          ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_REMOVED;
          state_nxt = ST_IDLE;
        end else begin
          p_nxt = p_inc;
        end
      end
      ST_DEC: begin
        cell_op[0]   = CELL_SET_DELTA;
        ld_ent.delta = (cell_ent[0].delta == '0) ? '0 : cell_ent[0].delta - 1'b1;
        state_nxt    = ST_WAKE;
      end
      ST_WAKE: begin
        if ((count_r != '0) && (woke_r < WW'(MAX_WAKE)) && (cell_ent[0].delta == '0)) begin
          for (int k = 0; k < DEPTH; k++) begin
            cell_op[k] = CELL_FROM_NEXT;
          end
          count_nxt = count_r - 1'b1;
          woke_nxt  = woke_r + 1'b1;
          ov_nxt    = 1'b1;
          os_nxt    = STS_WOKEN;
          oid_nxt   = cell_ent[0].id;
          ol_nxt    = !wake_more;
          if (!wake_more) state_nxt = ST_IDLE;
        end else begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; os_nxt = STS_NONE;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    t_r    <= t_nxt;
    id_r   <= id_nxt;
    woke_r <= woke_nxt;
    os_r   <= os_nxt;
    oid_r  <= oid_nxt;
    ol_r   <= ol_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = ov_r;
  assign out_status   = os_r;
  assign out_woken_id = oid_r;
  assign out_last     = ol_r;

endmodule
